/* src/smpq_pkg.sv */
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] key;
    logic [7:0]  payload;
  } item_t;

  typedef struct packed {
    logic [15:0] front_key;
    logic [7:0]  front_payload;
    logic        is_empty;
    logic [4:0]  entry_count;
    logic        dropped;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PUSH_FIRST,
    ST_POP_RD,
    ST_POP_MOV,
    ST_FRONT_RD,
    ST_DONE
  } state_t;

endpackage

/* src/sorted_min_priority_queue.sv */
`timescale 1ns / 1ps

// Bounded min-priority queue held as a key-ordered list in a small memory,
// front (smallest key) at address 0; equal keys leave in arrival order.
// A request is taken when start is high and busy is low; cmd.func selects
// push (key and payload) or pop. Every request yields exactly one result,
// shown on result for the single cycle in which done is high; the receiver
// cannot stall it, so it must take the result in that cycle. A push to a
// full queue is discarded with result.dropped set; a pop on an empty queue
// changes nothing. One memory port pair is shared by a small sequencer,
// and each entry that is examined or moved takes a registered read, then
// a compare and write. busy stays high from the cycle after start until
// done has been shown.
module sorted_min_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  smpq_pkg::item_t     cmd,
  output logic                busy,
  output logic                done,
  output smpq_pkg::result_t   result
);

  // sequencer state
  smpq_pkg::state_t state, state_next;

  // current memory address under the sequencer
  logic [smpq_pkg::IDX_W-1:0] idx, idx_next;
  // entries held
  logic [smpq_pkg::CNT_W-1:0] count, count_next;
  // request being served
  logic [smpq_pkg::KEY_BITS-1:0] new_key, new_key_next;
  logic [7:0]                    new_pay, new_pay_next;
  logic                          dropped, dropped_next;

  // entry store, one write and one registered read per cycle
  logic [smpq_pkg::KEY_BITS-1:0] key_mem [smpq_pkg::CAPACITY];
  logic [7:0]                    pay_mem [smpq_pkg::CAPACITY];
  logic [smpq_pkg::KEY_BITS-1:0] rd_key;
  logic [7:0]                    rd_pay;

  logic                          we;
  logic [smpq_pkg::IDX_W-1:0]    waddr;
  logic [smpq_pkg::KEY_BITS-1:0] wkey;
  logic [7:0]                    wpay;

  // helpers
  logic [smpq_pkg::CNT_W-1:0] cnt_dec;
  logic [smpq_pkg::IDX_W-1:0] last_idx;
  logic [smpq_pkg::IDX_W-1:0] idx_inc;
  logic [smpq_pkg::IDX_W-1:0] idx_dec;

  assign cnt_dec  = count - smpq_pkg::CNT_W'(1);
  assign last_idx = cnt_dec[smpq_pkg::IDX_W-1:0];
  assign idx_inc  = idx + smpq_pkg::IDX_W'(1);
  assign idx_dec  = idx - smpq_pkg::IDX_W'(1);

  // memory: write from the sequencer, read at idx every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    rd_key <= key_mem[idx];
    rd_pay <= pay_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= smpq_pkg::ST_IDLE;
      idx     <= '0;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  // request payload needs no reset
  always_ff @(posedge clk) begin
    new_key <= new_key_next;
    new_pay <= new_pay_next;
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    count_next   = count;
    dropped_next = dropped;
    new_key_next = new_key;
    new_pay_next = new_pay;
    we           = 1'b0;
    waddr        = idx_inc;
    wkey         = rd_key;
    wpay         = rd_pay;

    case (state)
      smpq_pkg::ST_IDLE: begin
        if (start) begin
          new_key_next = cmd.key[smpq_pkg::KEY_BITS-1:0];
          new_pay_next = cmd.payload;
          dropped_next = 1'b0;
          idx_next     = '0;
          if (cmd.func == smpq_pkg::FUNC_PUSH) begin
            if (count == smpq_pkg::CNT_W'(smpq_pkg::CAPACITY)) begin
              // full: discard and flag
              dropped_next = 1'b1;
              state_next   = smpq_pkg::ST_FRONT_RD;
            end else if (count == '0) begin
              we         = 1'b1;
              waddr      = '0;
              wkey       = cmd.key[smpq_pkg::KEY_BITS-1:0];
              wpay       = cmd.payload;
              count_next = smpq_pkg::CNT_W'(1);
              state_next = smpq_pkg::ST_FRONT_RD;
            end else begin
              // scan down from the back for the insertion point
              idx_next   = last_idx;
              state_next = smpq_pkg::ST_PUSH_RD;
            end
          end else begin
            if (count == '0) begin
              state_next = smpq_pkg::ST_FRONT_RD;
            end else if (count == smpq_pkg::CNT_W'(1)) begin
              count_next = '0;
              state_next = smpq_pkg::ST_FRONT_RD;
            end else begin
              idx_next   = smpq_pkg::IDX_W'(1);
              state_next = smpq_pkg::ST_POP_RD;
            end
          end
        end
      end

      smpq_pkg::ST_PUSH_RD: begin
        state_next = smpq_pkg::ST_PUSH_CMP;
      end

      smpq_pkg::ST_PUSH_CMP: begin
        we = 1'b1;
        if (rd_key > new_key) begin
          // larger key moves one place back
          if (idx == '0) begin
            state_next = smpq_pkg::ST_PUSH_FIRST;
          end else begin
            idx_next   = idx_dec;
            state_next = smpq_pkg::ST_PUSH_RD;
          end
        end else begin
          // insert behind entries with smaller or equal key
          wkey       = new_key;
          wpay       = new_pay;
          count_next = count + smpq_pkg::CNT_W'(1);
          idx_next   = '0;
          state_next = smpq_pkg::ST_FRONT_RD;
        end
      end

      smpq_pkg::ST_PUSH_FIRST: begin
        we         = 1'b1;
        waddr      = '0;
        wkey       = new_key;
        wpay       = new_pay;
        count_next = count + smpq_pkg::CNT_W'(1);
        idx_next   = '0;
        state_next = smpq_pkg::ST_FRONT_RD;
      end

      smpq_pkg::ST_POP_RD: begin
        state_next = smpq_pkg::ST_POP_MOV;
      end

      smpq_pkg::ST_POP_MOV: begin
        // move entry one place toward the front
        we    = 1'b1;
        waddr = idx_dec;
        if (idx == last_idx) begin
          count_next = cnt_dec;
          idx_next   = '0;
          state_next = smpq_pkg::ST_FRONT_RD;
        end else begin
          idx_next   = idx_inc;
          state_next = smpq_pkg::ST_POP_RD;
        end
      end

      smpq_pkg::ST_FRONT_RD: begin
        // idx is 0 here, front entry lands in rd_key / rd_pay
        state_next = smpq_pkg::ST_DONE;
      end

      smpq_pkg::ST_DONE: begin
        state_next = smpq_pkg::ST_IDLE;
      end

      default: begin
        state_next = smpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != smpq_pkg::ST_IDLE);
  assign done = (state == smpq_pkg::ST_DONE);

  // empty queue reports zero front
  always_comb begin
    result.is_empty      = (count == '0);
    result.entry_count   = 5'(count);
    result.dropped       = dropped;
    result.front_key     = result.is_empty ? 16'd0 : 16'(rd_key);
    result.front_payload = result.is_empty ? 8'd0 : rd_pay;
  end

endmodule

/* src/smpq_checker.sv */
`timescale 1ns / 1ps

module smpq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input smpq_pkg::result_t result
);

  // a taken request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but busy not raised");

  // a result is a single-cycle strobe that ends the request
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not a single strobe");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == 5'd0)))
    else $error("is_empty disagrees with entry_count");

  // empty queue shows a zero front
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |->
      (result.front_key == 16'd0 && result.front_payload == 8'd0))
    else $error("empty queue shows a nonzero front");

  // count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count <= 5'(smpq_pkg::CAPACITY)))
    else $error("entry_count above capacity");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* verif/sorted_min_priority_queue_tb.sv */
`timescale 1ns / 1ps

// request-level check of the sorted min-priority queue: every accepted request is
// run through a local sorted-list model, and each done strobe is matched in order
// against the oldest predicted result
module sorted_min_priority_queue_tb;

  localparam int RANDOM_REQUESTS = 800;
  // slowest request is a push landing at the front of fifteen entries
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [15:0] KEY_MASK = 16'((64'd1 << smpq_pkg::KEY_BITS) - 1);

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  payload;
  } entry_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  smpq_pkg::item_t   cmd = '0;
  logic              busy;
  logic              done;
  smpq_pkg::result_t result;

  smpq_pkg::item_t   pending_requests[$];
  smpq_pkg::result_t expected_results[$];
  entry_t            held_entries[$];     // model of the queue, front at index 0
  smpq_pkg::result_t want;
  int unsigned       burst_left = 0;
  int unsigned       gap_left = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  sorted_min_priority_queue dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  // apply one request to the model and return the result it should produce
  function automatic smpq_pkg::result_t apply_request(smpq_pkg::item_t req);
    smpq_pkg::result_t r;
    entry_t            e;
    int                pos;
    r = '0;
    if (req.func == smpq_pkg::FUNC_PUSH) begin
      if (held_entries.size() >= smpq_pkg::CAPACITY) begin
        // full: entry is thrown away and flagged
        r.dropped = 1'b1;
      end else begin
        e.key = req.key & KEY_MASK;
        e.payload = req.payload;
        // equal keys stay in arrival order, so skip past every key <= new one
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].key <= e.key) pos++;
        held_entries.insert(pos, e);
      end
    end else if (held_entries.size() > 0) begin
      held_entries.delete(0);
    end
    if (held_entries.size() == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.front_key = held_entries[0].key;
      r.front_payload = held_entries[0].payload;
    end
    r.entry_count = 5'(held_entries.size());
    return r;
  endfunction

  function automatic smpq_pkg::item_t make_request(logic f, logic [15:0] k, logic [7:0] p);
    smpq_pkg::item_t req;
    req.func = f;
    req.key = k;
    req.payload = p;
    return req;
  endfunction

  // driver: bursts of back-to-back requests separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // request taken at this edge, predict its result now
      if (start && !busy) expected_results.push_back(apply_request(cmd));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cmd <= pending_requests.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // a third of the bursts follow on with no gap at all
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: done is a one-cycle strobe, so every high sample is one result
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: key=%h payload=%h empty=%b count=%0d dropped=%b",
                   result.front_key, result.front_payload, result.is_empty,
                   result.entry_count, result.dropped);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_results.pop_front();
        if (result !== want) begin
          if (mismatches < 10) begin
            $display("mismatch: exp key=%h payload=%h empty=%b count=%0d dropped=%b",
                     want.front_key, want.front_payload, want.is_empty,
                     want.entry_count, want.dropped);
            $display("          got key=%h payload=%h empty=%b count=%0d dropped=%b",
                     result.front_key, result.front_payload, result.is_empty,
                     result.entry_count, result.dropped);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sorted_min_priority_queue_tb failed");
      $finish;
    end
  end

  initial begin
    int          n;
    int          seg_len;
    int          push_pct;
    int          key_mode;
    logic        f;
    logic [15:0] k;

    // directed: pop on empty, then fill to capacity with extreme keys and ties
    pending_requests.push_back(make_request(smpq_pkg::FUNC_POP, 16'h0000, 8'h00));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'hffff, 8'hff));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h0000, 8'h00));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h0000, 8'h01));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'hffff, 8'h00));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h8000, 8'haa));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h8000, 8'h55));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h7fff, 8'h0f));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h5555, 8'hf0));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'haaaa, 8'h33));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h0001, 8'hcc));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'hfffe, 8'h11));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h0000, 8'h22));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h1234, 8'h5a));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h8000, 8'ha5));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h00ff, 8'h81));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'hff00, 8'h7e));
    // now full: this push must be dropped
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h0000, 8'hee));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_POP, 16'hffff, 8'hff));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_POP, 16'h0000, 8'h00));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h0000, 8'h99));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'h4321, 8'h42));
    pending_requests.push_back(make_request(smpq_pkg::FUNC_PUSH, 16'hffff, 8'h66));

    // random: segments that lean toward filling, churning or draining, each with
    // its own key spread so that ties, full and empty states all come up often
    n = 0;
    while (n < RANDOM_REQUESTS) begin
      seg_len = $urandom_range(10, 50);
      case ($urandom_range(0, 2))
        0: begin
          push_pct = 85;
        end
        1: begin
          push_pct = 50;
        end
        default: begin
          push_pct = 15;
        end
      endcase
      key_mode = $urandom_range(0, 2);
      for (int j = 0; j < seg_len && n < RANDOM_REQUESTS; j++) begin
        f = ($urandom_range(0, 99) < push_pct) ? smpq_pkg::FUNC_PUSH : smpq_pkg::FUNC_POP;
        case (key_mode)
          0: begin
            k = 16'($urandom_range(0, 65535));
          end
          1: begin
            // narrow spread, mostly equal keys
            k = 16'($urandom_range(0, 3));
          end
          default: begin
            case ($urandom_range(0, 3))
              0: k = 16'h0000;
              1: k = 16'hffff;
              2: k = 16'h8000;
              default: k = 16'($urandom_range(0, 65535));
            endcase
          end
        endcase
        pending_requests.push_back(make_request(f, k, 8'($urandom_range(0, 255))));
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to be taken and every result to come back
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("sorted_min_priority_queue_tb passed");
    end else begin
      $display("sorted_min_priority_queue_tb failed");
    end
    $finish;
  end

endmodule
